// ===== sv/rbp_pkg.sv =====
// Shared constants, codes and types for the reference-counted block pool.
`timescale 1ns / 1ps
`default_nettype none
package rbp_pkg;

	localparam int MAX_BLOCKS = 256;
	localparam int REF_BITS   = 8;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int PTR_W      = IDX_W + 1;  // index plus the empty marker
	localparam int CFG_W      = 9;

	localparam logic [PTR_W-1:0]    EMPTY_MARK = PTR_W'(MAX_BLOCKS);
	localparam logic [REF_BITS-1:0] REF_MAX    = {REF_BITS{1'b1}};

	typedef enum logic [1:0] {
		K_ALLOC  = 2'd0,
		K_FREE   = 2'd1,
		K_ADDREF = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_BAD   = 2'd2,
		ST_SAT   = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	// Read and write requests for the count and link memories.
	typedef struct packed {
		logic                cnt_re;
		logic [IDX_W-1:0]    cnt_raddr;
		logic                cnt_we;
		logic [IDX_W-1:0]    cnt_waddr;
		logic [REF_BITS-1:0] cnt_wdata;
		logic                lnk_re;
		logic [IDX_W-1:0]    lnk_raddr;
		logic                lnk_we;
		logic [IDX_W-1:0]    lnk_waddr;
		logic [PTR_W-1:0]    lnk_wdata;
	} mem_req_t;

endpackage
`default_nettype wire

// ===== sv/rbp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module rbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== sv/rbp_core.sv =====
// Request sequencer: head pointers, count/link read-modify-write, result register.
`timescale 1ns / 1ps
`default_nettype none
module rbp_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [rbp_pkg::CFG_W-1:0]     cfg_wdata,
	input  wire logic                          in_valid,
	output      logic                          in_ready,
	input  wire logic [1:0]                    kind,
	input  wire logic [rbp_pkg::IDX_W-1:0]     block_index,
	output      logic                          out_valid,
	input  wire logic                          out_ready,
	output      logic [1:0]                    status,
	output      logic [rbp_pkg::IDX_W-1:0]     granted_index,
	output      logic [rbp_pkg::REF_BITS-1:0]  ref_after,
	output      logic                          returned_to_pool,
	output      rbp_pkg::mem_req_t             mem_req,
	input  wire logic [rbp_pkg::REF_BITS-1:0]  cnt_rdata,
	input  wire logic [rbp_pkg::PTR_W-1:0]     lnk_rdata
);
	import rbp_pkg::*;

	state_t              state_q, state_n;
	logic [CFG_W-1:0]    block_count_q;
	logic [PTR_W-1:0]    free_head_q, free_head_n;
	logic [PTR_W-1:0]    fresh_next_q, fresh_next_n;
	logic [1:0]          kind_s1;
	logic [IDX_W-1:0]    idx_s1;

	logic                out_valid_q;
	status_t             status_q, status_n;
	logic [IDX_W-1:0]    granted_q, granted_n;
	logic [REF_BITS-1:0] ref_q, ref_n;
	logic                ret_q, ret_n;

	logic                accept;
	logic                out_free;
	logic                finish;
	logic [PTR_W-1:0]    usable;
	logic [REF_BITS-1:0] cnt;
	logic [REF_BITS-1:0] cnt_dec;
	logic [IDX_W-1:0]    blk;
	logic                idx_ok;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign finish   = (state_q == S_EXEC) && out_free;

	// clamp the configured count to the pool size
	assign usable = (block_count_q > CFG_W'(MAX_BLOCKS)) ? EMPTY_MARK
	                                                      : PTR_W'(block_count_q);
	assign idx_ok = {1'b0, idx_s1} < usable;
	// blocks at or above fresh_next were never handed out since init: count 0
	assign cnt     = ({1'b0, idx_s1} < fresh_next_q) ? cnt_rdata : '0;
	assign cnt_dec = cnt - REF_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			block_count_q <= CFG_W'(MAX_BLOCKS);
			free_head_q   <= EMPTY_MARK;
			fresh_next_q  <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_we) begin
				block_count_q <= cfg_wdata;
				free_head_q   <= EMPTY_MARK;
				fresh_next_q  <= '0;
			end else if (finish) begin
				free_head_q  <= free_head_n;
				fresh_next_q <= fresh_next_n;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind;
			idx_s1  <= block_index;
		end
		if (finish) begin
			status_q  <= status_n;
			granted_q <= granted_n;
			ref_q     <= ref_n;
			ret_q     <= ret_n;
		end
	end

	always_comb begin
		state_n      = state_q;
		free_head_n  = free_head_q;
		fresh_next_n = fresh_next_q;
		status_n     = ST_BAD;
		granted_n    = '0;
		ref_n        = '0;
		ret_n        = 1'b0;
		blk          = '0;

		mem_req           = '0;
		mem_req.cnt_re    = accept;
		mem_req.cnt_raddr = block_index;
		mem_req.lnk_re    = accept;
		mem_req.lnk_raddr = free_head_q[IDX_W-1:0];

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_n = S_EXEC;
				end
			end
			S_EXEC: begin
				if (out_free) begin
					state_n = S_IDLE;
				end
				unique case (kind_s1)
					K_ALLOC: begin
						status_n = ST_EMPTY;
						if (!free_head_q[IDX_W]) begin
							blk         = free_head_q[IDX_W-1:0];
							free_head_n = lnk_rdata;
							status_n    = ST_OK;
						end else if (fresh_next_q < usable) begin
							blk          = fresh_next_q[IDX_W-1:0];
							fresh_next_n = fresh_next_q + PTR_W'(1);
							status_n     = ST_OK;
						end
						if (status_n == ST_OK) begin
							granted_n         = blk;
							ref_n             = REF_BITS'(1);
							mem_req.cnt_we    = finish;
							mem_req.cnt_waddr = blk;
							mem_req.cnt_wdata = REF_BITS'(1);
						end
					end
					K_FREE: begin
						if (idx_ok && cnt != '0) begin
							status_n          = ST_OK;
							ref_n             = cnt_dec;
							mem_req.cnt_we    = finish;
							mem_req.cnt_waddr = idx_s1;
							mem_req.cnt_wdata = cnt_dec;
							if (cnt_dec == '0) begin
								// relink at the head of the free list
								ret_n             = 1'b1;
								free_head_n       = {1'b0, idx_s1};
								mem_req.lnk_we    = finish;
								mem_req.lnk_waddr = idx_s1;
								mem_req.lnk_wdata = free_head_q;
							end
						end
					end
					K_ADDREF: begin
						if (idx_ok && cnt != '0) begin
							if (cnt == REF_MAX) begin
								status_n = ST_SAT;
								ref_n    = cnt;
							end else begin
								status_n          = ST_OK;
								ref_n             = cnt + REF_BITS'(1);
								mem_req.cnt_we    = finish;
								mem_req.cnt_waddr = idx_s1;
								mem_req.cnt_wdata = cnt + REF_BITS'(1);
							end
						end
					end
					default: begin
						status_n = ST_BAD;
					end
				endcase
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign granted_index    = granted_q;
	assign ref_after        = ref_q;
	assign returned_to_pool = ret_q;

`ifndef SYNTHESIS
	a_fresh_range: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_next_q <= EMPTY_MARK)
		else $error("fresh_next beyond pool");

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_head_q <= EMPTY_MARK)
		else $error("free_head beyond empty marker");

	a_write_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_req.cnt_we || mem_req.lnk_we) |-> (state_q == S_EXEC && out_free))
		else $error("memory write outside completion");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> out_valid_q)
		else $error("completed item did not raise a result");

	a_return_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && ret_q) |-> (ref_q == '0 && status_q == ST_OK))
		else $error("relinked block with nonzero count");
`endif

endmodule
`default_nettype wire

// ===== sv/refcounted_block_pool.sv =====
// Top level of the reference-counted block pool: sequencer plus count and link memories.
//
//  channel   | handshake              | payload
//  ----------+------------------------+----------------------------------------------
//  config    | cfg_we                 | cfg_wdata (block_count, 9 bits)
//  request   | in_valid / in_ready    | kind, block_index
//  result    | out_valid / out_ready  | status, granted_index, ref_after,
//            |                        | returned_to_pool
//
// Each item first reads the count memory at the addressed block and the link
// memory at the free-list head, then updates and writes back.
// The head pointer and fresh-block pointer live in flops and are settled by the
// write-back edge, so the next item's reads never overlap a pending write.
// Reset (arst_n) or a config write empties the pool at once: counts of blocks at
// or above the fresh pointer read as zero, so no clearing pass is needed.
// A result waits in the output register; the next item is taken meanwhile, and
// only its write-back stalls until the previous result has been taken.
`timescale 1ns / 1ps
`default_nettype none
module refcounted_block_pool (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [rbp_pkg::CFG_W-1:0]     cfg_wdata,
	input  wire logic                          in_valid,
	output      logic                          in_ready,
	input  wire logic [1:0]                    kind,
	input  wire logic [rbp_pkg::IDX_W-1:0]     block_index,
	output      logic                          out_valid,
	input  wire logic                          out_ready,
	output      logic [1:0]                    status,
	output      logic [rbp_pkg::IDX_W-1:0]     granted_index,
	output      logic [rbp_pkg::REF_BITS-1:0]  ref_after,
	output      logic                          returned_to_pool
);
	import rbp_pkg::*;

	mem_req_t            mem_req;
	logic [REF_BITS-1:0] cnt_rdata;
	logic [PTR_W-1:0]    lnk_rdata;

	rbp_core u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.kind             (kind),
		.block_index      (block_index),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.status           (status),
		.granted_index    (granted_index),
		.ref_after        (ref_after),
		.returned_to_pool (returned_to_pool),
		.mem_req          (mem_req),
		.cnt_rdata        (cnt_rdata),
		.lnk_rdata        (lnk_rdata)
	);

	// per-block reference counts
	rbp_ram #(
		.WIDTH (REF_BITS),
		.DEPTH (MAX_BLOCKS)
	) u_cnt_ram (
		.clk   (clk),
		.we    (mem_req.cnt_we),
		.waddr (mem_req.cnt_waddr),
		.wdata (mem_req.cnt_wdata),
		.re    (mem_req.cnt_re),
		.raddr (mem_req.cnt_raddr),
		.rdata (cnt_rdata)
	);

	// next-pointer of each freed block; only entries written by a free are used
	rbp_ram #(
		.WIDTH (PTR_W),
		.DEPTH (MAX_BLOCKS)
	) u_lnk_ram (
		.clk   (clk),
		.we    (mem_req.lnk_we),
		.waddr (mem_req.lnk_waddr),
		.wdata (mem_req.lnk_wdata),
		.re    (mem_req.lnk_re),
		.raddr (mem_req.lnk_raddr),
		.rdata (lnk_rdata)
	);

endmodule
`default_nettype wire
